@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the port checker bsc_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define BSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/bsc_pkg.sv @@
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bsc_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_COEF  = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_HIGH = 2'd2,
    CFG_PRESS_NINE = 2'd3
  } cfg_reg_e;

  // stream widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  // pressure divider: quotient bits and divisor magnitude width
  localparam int DivBits = 37;
  localparam int DivW    = 49;
  localparam int NumW    = 76;

  // pipeline depth: front stages, divider steps, back stages
  localparam int FrontStages = 10;
  localparam int BackStages  = 4;
  localparam int PipeDepth   = FrontStages + DivBits + BackStages;

  localparam logic [DivBits-1:0] QuotLimit   = 37'h10_0000_0000;
  localparam logic [11:0]        PressScale  = 12'd3125;
  localparam logic [25:0]        PressMax    = 26'h3FF_FFFF;
  localparam logic [20:0]        AdcFull     = 21'h10_0000;

  // item data carried alongside the divider
  typedef struct packed {
    logic [15:0] temp;
    logic        neg;
    logic        pv;
  } side_t;

  // item data carried through the front stages
  typedef struct packed {
    logic        mode;
    logic [19:0] adc_p;
    logic [15:0] temp;
  } carry_t;

endpackage

@@ rtl/core/barometric_sensor_compensation_unit.sv @@
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_unit
// Compensates raw temperature and pressure readings with calibration
// coefficients: temperature in 0.01 degree, pressure in Pa as Q18.8.
// ---------------------------------------------------------------------------
//  channel   | direction | transfer                      | payload
//  s_axis    | in        | tvalid & tready               | tdata: raw_t, raw_p; tuser: mode
//  m_axis    | out       | tvalid & tready               | tdata: temp, pressure; tuser: valid
//  cfg       | in        | cfg_we_i                      | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while the output is not stalled; the pipe holds the 37-step restoring
// divider (one quotient bit per stage) plus 10 front and 4 back stages.
// all stages move together; the whole pipe, empty stages included, halts
// while a result waits at the output and m_axis_tready is low, and
// s_axis_tready is low for exactly those cycles.
// reset clears the valid bits and the coefficient registers.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bsc_pkg::InDataW-1:0]  s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
  input  logic [0:0]                   s_axis_tuser,  // mode[0]
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bsc_pkg::OutDataW-1:0] m_axis_tdata,  // temperature_centi[15:0], pressure_q8[41:16], zero pad
  output logic [0:0]                   m_axis_tuser   // pressure_valid[0]
);

  localparam int DivBits = bsc_pkg::DivBits;
  localparam int DivW    = bsc_pkg::DivW;

  // coefficient registers
  logic [47:0] tcoef_q;
  logic [63:0] pclo_q;
  logic [63:0] pchi_q;
  logic [15:0] p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcoef_q <= '0;
      pclo_q  <= '0;
      pchi_q  <= '0;
      p9_q    <= '0;
    end else if (cfg_we_i) begin
      case (bsc_pkg::cfg_reg_e'(cfg_idx_i))
        bsc_pkg::CFG_TEMP_COEF:  tcoef_q <= cfg_wdata_i[47:0];
        bsc_pkg::CFG_PRESS_LOW:  pclo_q  <= cfg_wdata_i;
        bsc_pkg::CFG_PRESS_HIGH: pchi_q  <= cfg_wdata_i;
        bsc_pkg::CFG_PRESS_NINE: p9_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tcoef_q[15:0];
  assign t2 = $signed(tcoef_q[31:16]);
  assign t3 = $signed(tcoef_q[47:32]);
  assign p1 = pclo_q[15:0];
  assign p2 = $signed(pclo_q[31:16]);
  assign p3 = $signed(pclo_q[47:32]);
  assign p4 = $signed(pclo_q[63:48]);
  assign p5 = $signed(pchi_q[15:0]);
  assign p6 = $signed(pchi_q[31:16]);
  assign p7 = $signed(pchi_q[47:32]);
  assign p8 = $signed(pchi_q[63:48]);
  assign p9 = $signed(p9_q);

  // global advance: hold everything only while a result is stalled
  logic                          adv;
  logic [bsc_pkg::PipeDepth-1:0] vld_q;

  assign adv           = !vld_q[bsc_pkg::PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[bsc_pkg::PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[bsc_pkg::PipeDepth-2:0], s_axis_tvalid};
    end
  end

  // stage 1: temperature differences and first products
  logic [19:0]        adc_t;
  logic signed [18:0] a_s;
  logic signed [16:0] b_s;
  logic signed [34:0] at_d, at_q;
  logic signed [33:0] bb_d, bb_q;
  bsc_pkg::carry_t    car_q [1:8];

  assign adc_t = s_axis_tdata[19:0];
  assign a_s   = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign b_s   = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
  assign at_d  = a_s * t2;
  assign bb_d  = b_s * b_s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      at_q             <= at_d;
      bb_q             <= bb_d;
      car_q[1].mode    <= s_axis_tuser[0];
      car_q[1].adc_p   <= s_axis_tdata[39:20];
      car_q[1].temp    <= '0;
    end
  end

  // stage 2: scale the linear term, cubic-coefficient product
  logic signed [21:0] bbs;
  logic signed [23:0] ats_q;
  logic signed [37:0] bt_d, bt_q;

  assign bbs  = $signed(bb_q[33:12]);
  assign bt_d = bbs * t3;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ats_q    <= $signed(at_q[34:11]);
      bt_q     <= bt_d;
      car_q[2] <= car_q[1];
    end
  end

  // stage 3: fine temperature, centi-degree temperature, offset v
  logic signed [24:0] fine;
  logic signed [27:0] t5;
  logic signed [19:0] ts;
  logic [15:0]        temp_d;
  logic signed [25:0] v_d, v_q;

  assign fine = $signed({ats_q[23], ats_q}) + $signed({bt_q[37], bt_q[37:14]});
  assign t5   = $signed({{3{fine[24]}}, fine}) + $signed({fine[24], fine, 2'b00})
                + 28'sd128;
  assign ts   = t5[27:8];
  assign v_d  = $signed({fine[24], fine}) - 26'sd128000;

  // saturate to the 16-bit range
  always_comb begin
    if (!ts[19] && (ts[18:15] != 4'h0)) begin
      temp_d = 16'h7FFF;
    end else if (ts[19] && (ts[18:15] != 4'hF)) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = ts[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q           <= v_d;
      car_q[3].mode  <= car_q[2].mode;
      car_q[3].adc_p <= car_q[2].adc_p;
      car_q[3].temp  <= temp_d;
    end
  end

  // stage 4: v squared and linear pressure products
  logic signed [51:0] vv_q;
  logic signed [41:0] vp5_q, vp2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vv_q     <= v_q * v_q;
      vp5_q    <= v_q * p5;
      vp2_q    <= v_q * p2;
      car_q[4] <= car_q[3];
    end
  end

  // stage 5: quadratic pressure products
  logic signed [67:0] vvp6_q, vvp3_q;
  logic signed [41:0] vp5b_q, vp2b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vvp6_q   <= vv_q * p6;
      vvp3_q   <= vv_q * p3;
      vp5b_q   <= vp5_q;
      vp2b_q   <= vp2_q;
      car_q[5] <= car_q[4];
    end
  end

  // stage 6: offset sum w2 and sensitivity sum w1
  logic [63:0] w2_d, w2_q, w1_d, w1_q;

  assign w2_d = vvp6_q[63:0] + {{5{vp5b_q[41]}}, vp5b_q, 17'b0}
                + {{13{p4[15]}}, p4, 35'b0};
  assign w1_d = {{4{vvp3_q[67]}}, vvp3_q[67:8]} + {{10{vp2b_q[41]}}, vp2b_q, 12'b0}
                + 64'h0000_8000_0000_0000;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w2_q     <= w2_d;
      w1_q     <= w1_d;
      car_q[6] <= car_q[5];
    end
  end

  // stage 7: dividend, split divisor products
  logic [20:0]        adc_inv;
  logic [63:0]        d_q;
  logic signed [30:0] w1_hi;
  logic signed [47:0] hip1_q;
  logic [48:0]        lop1_q;

  assign adc_inv = bsc_pkg::AdcFull - {1'b0, car_q[6].adc_p};
  assign w1_hi   = $signed(w1_q[63:33]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q      <= {12'b0, adc_inv, 31'b0} - w2_q;
      hip1_q   <= w1_hi * $signed({1'b0, p1});
      lop1_q   <= w1_q[32:0] * p1;
      car_q[7] <= car_q[6];
    end
  end

  // stage 8: divisor sum, dividend magnitude
  logic signed [DivW-1:0] div_q;
  logic [63:0]            magd_q;
  logic                   negd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q    <= $signed({hip1_q[47], hip1_q}) + $signed({33'b0, lop1_q[48:33]});
      magd_q   <= d_q[63] ? (64'd0 - d_q) : d_q;
      negd_q   <= d_q[63];
      car_q[8] <= car_q[7];
    end
  end

  // stage 9: scaled dividend, divisor magnitude, result sign and validity
  logic [bsc_pkg::NumW-1:0] num_q;
  logic [DivW-1:0]          mag_m_q;
  bsc_pkg::side_t           side9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q        <= magd_q * bsc_pkg::PressScale;
      mag_m_q      <= div_q[DivW-1] ? (DivW'(0) - div_q) : div_q;
      side9_q.temp <= car_q[8].temp;
      side9_q.neg  <= negd_q ^ div_q[DivW-1];
      side9_q.pv   <= !car_q[8].mode && (div_q != '0);
    end
  end

  // stage 10: quotient overflow check and divider load
  logic [DivW-1:0]    drem_q [0:DivBits-1];
  logic [DivW-1:0]    dm_q   [0:DivBits-1];
  logic [DivBits-1:0] dnlo_q [0:DivBits];
  logic               dovf_q [0:DivBits];
  bsc_pkg::side_t     dside_q[0:DivBits];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drem_q[0]  <= {10'b0, num_q[bsc_pkg::NumW-1:DivBits]};
      dnlo_q[0]  <= num_q[DivBits-1:0];
      dm_q[0]    <= mag_m_q;
      dovf_q[0]  <= {10'b0, num_q[bsc_pkg::NumW-1:DivBits]} >= mag_m_q;
      dside_q[0] <= side9_q;
    end
  end

  // restoring divider, one quotient bit per stage shifted into dnlo
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    logic          ge;

    assign trial = {drem_q[k], dnlo_q[k][DivBits-1]};
    assign diff  = trial - {1'b0, dm_q[k]};
    assign ge    = trial >= {1'b0, dm_q[k]};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dnlo_q[k+1]  <= {dnlo_q[k][DivBits-2:0], ge};
        dovf_q[k+1]  <= dovf_q[k];
        dside_q[k+1] <= dside_q[k];
      end
    end

    if (k < DivBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          drem_q[k+1] <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
          dm_q[k+1]   <= dm_q[k];
        end
      end
    end
  end

  // back 1: saturate the quotient and apply the sign
  logic [DivBits-1:0] qsat;
  logic signed [37:0] pp_q;
  bsc_pkg::side_t     sideb1_q;

  assign qsat = (dovf_q[DivBits] || dnlo_q[DivBits][DivBits-1]) ? bsc_pkg::QuotLimit
                                                                : dnlo_q[DivBits];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q     <= dside_q[DivBits].neg ? (38'd0 - {1'b0, qsat}) : {1'b0, qsat};
      sideb1_q <= dside_q[DivBits];
    end
  end

  // back 2: second-order products
  logic signed [24:0] ps;
  logic signed [49:0] ss_q;
  logic signed [53:0] p8p_q;
  logic signed [37:0] pp2_q;
  bsc_pkg::side_t     sideb2_q;

  assign ps = pp_q[37:13];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ss_q     <= ps * ps;
      p8p_q    <= p8 * pp_q;
      pp2_q    <= pp_q;
      sideb2_q <= sideb1_q;
    end
  end

  // back 3: correction terms
  logic signed [65:0] c1_q;
  logic signed [34:0] c2_q;
  logic signed [37:0] pp3_q;
  bsc_pkg::side_t     sideb3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q     <= p9 * ss_q;
      c2_q     <= $signed(p8p_q[53:19]);
      pp3_q    <= pp2_q;
      sideb3_q <= sideb2_q;
    end
  end

  // back 4: final sum, offset, clamp into the output register
  logic [41:0] psum;
  logic [34:0] pres;
  logic [25:0] press_d;
  logic [15:0] temp_o_q;
  logic [25:0] press_o_q;
  logic        pv_o_q;

  assign psum = {{4{pp3_q[37]}}, pp3_q} + {c1_q[65], c1_q[65:25]}
                + {{7{c2_q[34]}}, c2_q};
  assign pres = {psum[41], psum[41:8]} + {{15{p7[15]}}, p7, 4'b0};

  always_comb begin
    if (!sideb3_q.pv || pres[34]) begin
      press_d = '0;
    end else if (pres[33:26] != 8'h00) begin
      press_d = bsc_pkg::PressMax;
    end else begin
      press_d = pres[25:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_o_q  <= sideb3_q.temp;
      press_o_q <= press_d;
      pv_o_q    <= sideb3_q.pv;
    end
  end

  assign m_axis_tdata = {6'b0, press_o_q, temp_o_q};
  assign m_axis_tuser = pv_o_q;

endmodule

@@ rtl/core/bsc_checker.sv @@
// ---------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the compensation unit, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bsc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  // a stalled result holds its data
  `BSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // input side stops only while a result is stalled
  `BSC_ASSERT_IMPLY(a_ready_link, clk_i, rst_ni, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // an invalid pressure reads zero
  `BSC_ASSERT_IMPLY(a_press_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[41:16] == 26'd0)

  // padding bits stay clear
  `BSC_ASSERT_IMPLY(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[47:42] == 6'd0)

endmodule

bind barometric_sensor_compensation_unit bsc_checker u_bsc_checker (.*);

@@ tb/barometric_sensor_compensation_checker.sv @@
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_checker
// Watches the input, output and configuration ports of the compensation
// unit, predicts each reading with exact wide arithmetic and compares.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [bsc_pkg::InDataW-1:0]  s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
  input  logic [0:0]                   s_axis_tuser,  // mode[0]
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [bsc_pkg::OutDataW-1:0] m_axis_tdata,  // temperature_centi[15:0], pressure_q8[41:16]
  input  logic [0:0]                   m_axis_tuser,  // pressure_valid[0]
  output int                           pending_o,
  output int                           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [25:0] press;
    logic        valid;
  } reading_t;

  logic [47:0] temp_coef;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_nine;

  reading_t expected_readings[$];

  function automatic wide_t uext(input logic [19:0] x);
    return $signed({108'd0, x});
  endfunction

  function automatic wide_t sext(input logic [15:0] x);
    return $signed({{112{x[15]}}, x});
  endfunction

  // exact fixed-point compensation of one raw sample pair
  function automatic reading_t compensate(input logic mode, input logic [19:0] rt,
                                          input logic [19:0] rp);
    wide_t one, adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    wide_t a, b, fine, tc, v, w1, w2, dv, d, md, mm, q, p, s, c1, c2, r;
    reading_t res;
    one   = 1;
    adc_t = uext(rt);
    adc_p = uext(rp);
    t1 = $signed({112'd0, temp_coef[15:0]});
    t2 = sext(temp_coef[31:16]);
    t3 = sext(temp_coef[47:32]);
    p1 = $signed({112'd0, press_low[15:0]});
    p2 = sext(press_low[31:16]);
    p3 = sext(press_low[47:32]);
    p4 = sext(press_low[63:48]);
    p5 = sext(press_high[15:0]);
    p6 = sext(press_high[31:16]);
    p7 = sext(press_high[47:32]);
    p8 = sext(press_high[63:48]);
    p9 = sext(press_nine);

    // temperature
    a    = (adc_t >>> 3) - t1 * 2;
    b    = (adc_t >>> 4) - t1;
    fine = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
    tc   = (fine * 5 + 128) >>> 8;
    if (tc < -32768) tc = -32768;
    if (tc > 32767) tc = 32767;
    res.temp  = tc[15:0];
    res.press = '0;
    res.valid = 1'b0;

    // pressure
    if (!mode) begin
      v  = fine - 128000;
      w2 = v * v * p6 + v * p5 * 131072 + (p4 <<< 35);
      w1 = ((v * v * p3) >>> 8) + v * p2 * 4096 + (one <<< 47);
      dv = (w1 * p1) >>> 33;
      if (dv != 0) begin
        d  = ((1048576 - adc_p) <<< 31) - w2;
        md = (d < 0) ? -d : d;
        mm = (dv < 0) ? -dv : dv;
        q  = (md * 3125) / mm;
        if (q > (one <<< 36)) q = one <<< 36;
        p  = ((d < 0) != (dv < 0)) ? -q : q;
        s  = p >>> 13;
        c1 = (p9 * s * s) >>> 25;
        c2 = (p8 * p) >>> 19;
        r  = ((p + c1 + c2) >>> 8) + p7 * 16;
        if (r < 0) r = 0;
        if (r > 67108863) r = 67108863;
        res.press = r[25:0];
        res.valid = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
    errors_o++;
  endtask

  // track configuration, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      temp_coef  <= '0;
      press_low  <= '0;
      press_high <= '0;
      press_nine <= '0;
      expected_readings.delete();
      pending_o  <= 0;
      errors_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (bsc_pkg::cfg_reg_e'(cfg_idx_i))
          bsc_pkg::CFG_TEMP_COEF:  temp_coef  <= cfg_wdata_i[47:0];
          bsc_pkg::CFG_PRESS_LOW:  press_low  <= cfg_wdata_i;
          bsc_pkg::CFG_PRESS_HIGH: press_high <= cfg_wdata_i;
          bsc_pkg::CFG_PRESS_NINE: press_nine <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(compensate(s_axis_tuser[0], s_axis_tdata[19:0],
                                               s_axis_tdata[39:20]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result, temperature", m_axis_tdata[15:0], 0);
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[15:0] !== want.temp)
            report_mismatch("temperature_centi", $signed(m_axis_tdata[15:0]),
                            $signed(want.temp));
          if (m_axis_tdata[41:16] !== want.press)
            report_mismatch("pressure_q8", m_axis_tdata[41:16], want.press);
          if (m_axis_tuser[0] !== want.valid)
            report_mismatch("pressure_valid", m_axis_tuser[0], want.valid);
        end
      end
      pending_o <= expected_readings.size();
    end
  end

endmodule

@@ tb/barometric_sensor_compensation_unit_test.sv @@
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_unit_test
// Drives directed and random raw readings through the compensation unit
// under several coefficient sets and idle patterns; a checker predicts.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [bsc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [bsc_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [bsc_pkg::OutDataW-1:0] m_axis_tdata;
  logic [0:0]                   m_axis_tuser;
  int                           pending;
  int                           errors;
  int                           send_idle;
  int                           recv_stall;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  barometric_sensor_compensation_unit dut (.*);

  barometric_sensor_compensation_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .errors_o(errors)
  );

  // receiver stalls
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // one input transfer, with a random gap before it
  task automatic send_reading(input logic mode, input logic [19:0] rt, input logic [19:0] rp);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rp, rt};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // write all four registers while the pipe is empty
  task automatic load_coefficients(input logic [47:0] tc, input logic [63:0] pl,
                                   input logic [63:0] ph, input logic [15:0] p9);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_idx_i <= bsc_pkg::CFG_TEMP_COEF;  cfg_wdata_i <= {16'd0, tc};
    @(posedge clk_i);
    cfg_idx_i <= bsc_pkg::CFG_PRESS_LOW;  cfg_wdata_i <= pl;
    @(posedge clk_i);
    cfg_idx_i <= bsc_pkg::CFG_PRESS_HIGH; cfg_wdata_i <= ph;
    @(posedge clk_i);
    cfg_idx_i <= bsc_pkg::CFG_PRESS_NINE; cfg_wdata_i <= {48'd0, p9};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_readings(input int count, input int mode_sel);
    logic [19:0] rt, rp;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && mode_sel == 1) wait_drained();
      if ($urandom_range(3) != 0) begin
        rt = 20'd519888 + 20'($urandom_range(60000)) - 20'd30000;
        rp = 20'd415148 + 20'($urandom_range(200000)) - 20'd100000;
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      send_reading($urandom_range(4) == 0, rt, rp);
    end
  endtask

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [47:0] tc_nom;
    logic [63:0] pl_nom, ph_nom;
    tc_nom = {16'hFC18, 16'd26435, 16'd27504};
    pl_nom = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    ph_nom = {16'hC708, 16'd15500, 16'hFFF9, 16'd140};
    send_idle  = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: zero divisor, both modes, field extremes
    send_reading(1'b0, 20'd0, 20'd0);
    send_reading(1'b1, 20'hFFFFF, 20'hFFFFF);
    send_reading(1'b0, 20'hFFFFF, 20'd0);
    send_reading(1'b1, 20'd0, 20'hFFFFF);

    // nominal calibration
    load_coefficients(tc_nom, pl_nom, ph_nom, 16'd6000);
    send_reading(1'b0, 20'd519888, 20'd415148);
    send_reading(1'b1, 20'd519888, 20'd415148);
    send_reading(1'b0, 20'd0, 20'd0);
    send_reading(1'b0, 20'hFFFFF, 20'hFFFFF);
    send_reading(1'b0, 20'd0, 20'hFFFFF);
    send_reading(1'b0, 20'hFFFFF, 20'd0);
    send_reading(1'b1, 20'hFFFFF, 20'd0);
    send_reading(1'b0, 20'hAAAAA, 20'h55555);
    send_reading(1'b0, 20'h55555, 20'hAAAAA);

    // coefficient extremes
    load_coefficients('1, '1, '1, 16'h7FFF);
    send_reading(1'b0, 20'd0, 20'd0);
    send_reading(1'b0, 20'hFFFFF, 20'hFFFFF);
    send_reading(1'b1, 20'hFFFFF, 20'd7);
    load_coefficients({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                      {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_reading(1'b0, 20'd0, 20'hFFFFF);
    send_reading(1'b0, 20'hFFFFF, 20'd0);
    send_reading(1'b0, 20'd123456, 20'd654321);

    // random phases across idle patterns and coefficient sets
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      if (ph < 4)
        load_coefficients(tc_nom ^ 48'($urandom_range(255)), pl_nom ^ 64'($urandom_range(255)),
                          ph_nom ^ 64'($urandom_range(255)), 16'($urandom));
      else if (ph == 4)
        load_coefficients('0, '0, '0, '0);
      else
        load_coefficients(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom));
      random_readings(200, ph);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/barometric_sensor_compensation_unit.sv
rtl/core/bsc_checker.sv
tb/barometric_sensor_compensation_checker.sv
tb/barometric_sensor_compensation_unit_test.sv
